// File: src/clis_pkg.sv
// ----------------------------------------------------------------------------
// clis_pkg
// Types and constants shared by the blocks that count longest strictly
// increasing subsequences, and the saturating count adder of the datapath.
// ----------------------------------------------------------------------------
package clis_pkg;

	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 63;
	localparam int LEN_OUT_W = 11;

	localparam logic [COUNT_W-1:0]   COUNT_MAX     = {COUNT_W{1'b1}};
	localparam logic [LEN_OUT_W-1:0] LEN_FIELD_MAX = {LEN_OUT_W{1'b1}};

	// one input transfer
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_t;

	// one result transfer
	typedef struct packed {
		logic [LEN_OUT_W-1:0] lis_length;
		logic [COUNT_W-1:0]   path_count;
		logic                 count_saturated;
		logic                 too_many_items;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic drop;
		logic rd;
		logic commit;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_end;
		logic in_last;
		logic held_last;
	} status_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sum;
		logic               sat;
	} sat_sum_t;

	// both operands are at most COUNT_MAX, so overflow shows in the top bit
	function automatic sat_sum_t sat_add(input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		sat_sum_t         r;
		s     = {1'b0, a} + {1'b0, b};
		r.sat = s[COUNT_W];
		r.sum = s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
		return r;
	endfunction

endpackage

// File: src/clis_ram.sv
// ----------------------------------------------------------------------------
// clis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/clis_ctrl.sv
// ----------------------------------------------------------------------------
// clis_ctrl
// Sequencer: accepts an item, walks the stored entries, commits the new
// entry (or drops the item when the store is full) and issues the result on the final item.
// ----------------------------------------------------------------------------
module clis_ctrl import clis_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	assign busy = busy_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (status.full) begin
						state_d = status.in_last ? ST_EMIT : ST_IDLE;
					end else if (status.empty) begin
						state_d = ST_COMMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (status.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = status.held_last ? ST_EMIT : ST_IDLE;
			ST_EMIT:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && start;
		cmd.drop   = (state_q == ST_IDLE) && start && status.full;
		cmd.rd     = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT);
		cmd.emit   = (state_q == ST_EMIT);
	end

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

endmodule

// File: src/clis_dp.sv
// ----------------------------------------------------------------------------
// clis_dp
// Datapath: entry store, scan address, best-length accumulator for the
// current item, running maximum and total, and the result register.
// ----------------------------------------------------------------------------
module clis_dp import clis_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  in_t     item,
	input  cmd_t    cmd,
	output status_t status,
	output logic    done,
	output out_t    result
);

	localparam int AW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW     = $clog2(MAX_ITEMS + 1);
	localparam int LW     = CW;
	localparam int WORD_W = VALUE_W + LW + COUNT_W;
	localparam int LCMP   = (LW > LEN_OUT_W) ? LW : LEN_OUT_W;

	in_t                item_q;
	logic [CW-1:0]      n_q;
	logic [AW-1:0]      j_q;
	logic               rd_valid_s1;
	logic [LW-1:0]      cur_len_q;
	logic [COUNT_W-1:0] cur_cnt_q;
	logic [LW-1:0]      best_len_q;
	logic [COUNT_W-1:0] best_cnt_q;
	logic               sat_q;
	logic               drop_q;
	logic               done_q;
	out_t               result_q;

	logic [WORD_W-1:0]         wdata;
	logic [WORD_W-1:0]         rdata;
	logic signed [VALUE_W-1:0] rd_value;
	logic [LW-1:0]             rd_len;
	logic [COUNT_W-1:0]        rd_cnt;
	logic [LW-1:0]             cand;
	sat_sum_t                  scan_sum;
	sat_sum_t                  best_sum;
	logic [LCMP-1:0]           best_ext;

	// entry store: value, length and count per position
	assign wdata = {item_q.value, cur_len_q, cur_cnt_q};

	clis_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (n_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (j_q),
		.rdata (rdata)
	);

	assign rd_value = $signed(rdata[WORD_W-1 -: VALUE_W]);
	assign rd_len   = rdata[COUNT_W +: LW];
	assign rd_cnt   = rdata[COUNT_W-1:0];
	assign cand     = LW'(rd_len + 1'b1);
	assign scan_sum = sat_add(cur_cnt_q, rd_cnt);
	assign best_sum = sat_add(best_cnt_q, cur_cnt_q);
	assign best_ext = LCMP'(best_len_q);

	// status to the controller
	always_comb begin
		status.full      = (n_q == CW'(MAX_ITEMS));
		status.empty     = (n_q == '0);
		status.scan_end  = ((CW'(j_q) + CW'(1)) == n_q);
		status.in_last   = item.last;
		status.held_last = item_q.last;
	end

	// held item, scan address and per-item accumulator
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q    <= item;
			j_q       <= '0;
			cur_len_q <= LW'(1);
			cur_cnt_q <= COUNT_W'(1);
		end else begin
			if (cmd.rd) begin
				j_q <= AW'(j_q + 1'b1);
			end
			// strictly smaller earlier entry: longer wins, ties add counts
			if (rd_valid_s1 && (item_q.value > rd_value)) begin
				if (cand > cur_len_q) begin
					cur_len_q <= cand;
					cur_cnt_q <= rd_cnt;
				end else if (cand == cur_len_q) begin
					cur_cnt_q <= scan_sum.sum;
				end
			end
		end
	end

	// control state of the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			n_q         <= '0;
			best_len_q  <= '0;
			best_cnt_q  <= '0;
			sat_q       <= 1'b0;
			drop_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd;
			done_q      <= cmd.emit;
			if (rd_valid_s1 && (item_q.value > rd_value) && (cand == cur_len_q)
				&& scan_sum.sat) begin
				sat_q <= 1'b1;
			end
			if (cmd.drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.commit) begin
				n_q <= CW'(n_q + 1'b1);
				if (cur_len_q == best_len_q) begin
					best_cnt_q <= best_sum.sum;
					if (best_sum.sat) begin
						sat_q <= 1'b1;
					end
				end else if (cur_len_q > best_len_q) begin
					best_len_q <= cur_len_q;
					best_cnt_q <= cur_cnt_q;
				end
			end
			// result goes out, sequence starts over
			if (cmd.emit) begin
				n_q        <= '0;
				best_len_q <= '0;
				best_cnt_q <= '0;
				sat_q      <= 1'b0;
				drop_q     <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.lis_length      <= (best_ext > LCMP'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX
				: best_ext[LEN_OUT_W-1:0];
			result_q.path_count      <= best_cnt_q;
			result_q.count_saturated <= sat_q;
			result_q.too_many_items  <= drop_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: src/count_longest_increasing_core.sv
// ----------------------------------------------------------------------------
// count_longest_increasing_core
// Counts the longest strictly increasing subsequences of a stream of signed
// values; one result after the item flagged last.
// ----------------------------------------------------------------------------
// an item that finds entries stored is accepted, reads each of them through
// the single RAM read port at one per cycle, then drains and commits; the
// first item of a sequence finds none and goes straight from accept to commit;
// a final item adds an emit step, and done pulses in the cycle after it; the
// receiver cannot stall it; a dropped item ends at accept, and a final one emits
// the core takes no new item until it is ready again
// arst_n clears the sequence state; the RAM needs no clearing pass
module count_longest_increasing_core import clis_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	cmd_t    cmd;
	status_t status;

	clis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	clis_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

// File: src/clis_chk.sv
// ----------------------------------------------------------------------------
// clis_chk
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
module clis_chk import clis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	// the core only turns busy after a start
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("core turned busy without a transfer");

	// a result pulse lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// the result shows once the core is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while core busy");

	// an empty sequence has no paths, a nonempty one has at least one
	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.lis_length == '0) == (result.path_count == '0)))
		else $error("length and path count disagree");

endmodule

bind count_longest_increasing_core clis_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
